>>> rtl/level_statistics_db_core_assert.svh
// Assertion macros used by the level statistics controller.
// Expects clk and rst_n in scope at the point of use.
`ifndef LEVEL_STATISTICS_DB_CORE_ASSERT_SVH
`define LEVEL_STATISTICS_DB_CORE_ASSERT_SVH

// same-cycle implication
`define LSDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lsdb_pkg.sv
// Shared types and constants for the level statistics block.
// No dependencies.
package lsdb_pkg;

    localparam int MAX_ITEMS   = 4096;
    localparam int CNT_W       = 13;
    localparam int LVL_W       = 17;
    localparam int SUM_W       = 29;
    localparam int SQ_W        = 46;
    localparam int OPND_W      = 57;
    localparam int LOG_ITERS   = 24;
    localparam logic [LVL_W-1:0] LEVEL_ONE = 17'd65536;
    localparam logic signed [27:0] DB_K = 28'sd101008905;
    localparam logic [15:0] DB_FLOOR = 16'h8000;

    localparam logic [1:0] OUT_MIN    = 2'd0;
    localparam logic [1:0] OUT_MAX    = 2'd1;
    localparam logic [1:0] OUT_MEAN   = 2'd2;
    localparam logic [1:0] OUT_SPREAD = 2'd3;

    typedef struct packed {
        logic [LVL_W-1:0] rms_level;
        logic             last_item;
    } lsdb_in_t;

    typedef struct packed {
        logic signed [15:0] min_db;
        logic signed [15:0] max_db;
        logic signed [15:0] mean_db;
        logic signed [15:0] spread_db;
        logic [CNT_W-1:0]   item_count;
        logic [3:0]         floor_flags;
        logic               overflow;
    } lsdb_out_t;

    typedef struct packed {
        logic       acc_en;
        logic       prep_mul;
        logic       prep_sum;
        logic       l_init;
        logic       log_load;
        logic       log_shift;
        logic       log_mul;
        logic       log_upd;
        logic       l_add;
        logic       l_sub;
        logic       db_mul;
        logic       db_rnd;
        logic       write_field;
        logic       load_out;
        logic [1:0] sel_out;
        logic       sel_second;
    } lsdb_cmd_t;

    typedef struct packed {
        logic [3:0] flags;
        logic       norm_top;
    } lsdb_stat_t;

endpackage

>>> rtl/lsdb_dpath.sv
// Datapath: accumulators, shared log2 unit, dB scaling and result registers.
// Depends on lsdb_pkg.
module lsdb_dpath
    import lsdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lsdb_in_t   in_word,
    input  lsdb_cmd_t  cmd,
    output lsdb_stat_t stat,
    output lsdb_out_t  out_word
);

    logic [CNT_W-1:0]  count_reg;
    logic [LVL_W-1:0]  min_reg;
    logic [LVL_W-1:0]  max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              drop_reg;

    logic [35:0]       pl_reg;
    logic [35:0]       ph_reg;
    logic [57:0]       s2_reg;
    logic [25:0]       d_reg;
    logic [OPND_W-1:0] nn_reg;

    logic [OPND_W-1:0] xr_reg;
    logic [5:0]        e_reg;
    logic [31:0]       m_reg;
    logic [23:0]       f_reg;
    logic [63:0]       sqp_reg;
    logic signed [31:0] lacc_reg;
    logic signed [59:0] prod_reg;
    logic [15:0]       db_reg;
    logic [15:0]       fld_reg [4];
    lsdb_out_t         out_reg;

    logic [LVL_W-1:0]  x_clamp;
    logic [33:0]       x_sq;
    logic [35:0]       pl_mul;
    logic [35:0]       ph_mul;
    logic [57:0]       s2_mul;
    logic [25:0]       d_mul;
    logic [OPND_W-1:0] opnd;
    logic [32:0]       t_sq;
    logic signed [31:0] l_val;
    logic [59:0]       mag;
    logic [60:0]       rsum;
    logic [20:0]       r;
    logic [15:0]       db_next;
    logic [57:0]       nn_full;

    assign x_clamp = (in_word.rms_level > LEVEL_ONE) ? LEVEL_ONE : in_word.rms_level;
    assign x_sq    = x_clamp * x_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= LEVEL_ONE;
            max_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            count_reg <= '0;
            min_reg   <= LEVEL_ONE;
            max_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (count_reg < CNT_W'(MAX_ITEMS))
            begin
                count_reg <= count_reg + 1'b1;
                if (x_clamp < min_reg)
                    min_reg <= x_clamp;
                if (x_clamp > max_reg)
                    max_reg <= x_clamp;
                sum_reg <= sum_reg + SUM_W'(x_clamp);
                sq_reg  <= sq_reg + SQ_W'(x_sq);
            end
            else
            begin
                drop_reg <= 1'b1;
            end
        end
    end

    assign pl_mul  = count_reg * sq_reg[22:0];
    assign ph_mul  = count_reg * sq_reg[45:23];
    assign s2_mul  = sum_reg * sum_reg;
    assign d_mul   = count_reg * (count_reg - 1'b1);
    assign nn_full = {ph_reg[34:0], 23'b0} + 58'(pl_reg) - s2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.prep_mul)
        begin
            pl_reg <= pl_mul;
            ph_reg <= ph_mul;
            s2_reg <= s2_mul;
            d_reg  <= d_mul;
        end
        if (cmd.prep_sum)
            nn_reg <= nn_full[OPND_W-1:0];
    end

    assign stat.flags[0] = (min_reg == '0);
    assign stat.flags[1] = (max_reg == '0);
    assign stat.flags[2] = (count_reg == '0) || (sum_reg == '0);
    assign stat.flags[3] = (count_reg < CNT_W'(2)) || (nn_reg == '0);
    assign stat.norm_top = xr_reg[OPND_W-1];

    always_comb
    begin
        unique case (cmd.sel_out)
            OUT_MIN:    opnd = OPND_W'(min_reg);
            OUT_MAX:    opnd = OPND_W'(max_reg);
            OUT_MEAN:   opnd = cmd.sel_second ? OPND_W'(count_reg) : OPND_W'(sum_reg);
            OUT_SPREAD: opnd = cmd.sel_second ? OPND_W'(d_reg) : nn_reg;
            default:    opnd = '0;
        endcase
    end

    assign t_sq  = sqp_reg[63:31];
    assign l_val = 32'({e_reg, f_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.log_load)
        begin
            xr_reg <= opnd;
            e_reg  <= 6'(OPND_W - 1);
        end
        else if (cmd.log_shift)
        begin
            if (xr_reg[OPND_W-1])
            begin
                m_reg <= xr_reg[OPND_W-1 -: 32];
                f_reg <= '0;
            end
            else
            begin
                xr_reg <= {xr_reg[OPND_W-2:0], 1'b0};
                e_reg  <= e_reg - 1'b1;
            end
        end
        if (cmd.log_mul)
            sqp_reg <= m_reg * m_reg;
        if (cmd.log_upd)
        begin
            f_reg <= {f_reg[22:0], t_sq[32]};
            m_reg <= t_sq[32] ? t_sq[32:1] : t_sq[31:0];
        end
        if (cmd.l_init)
            lacc_reg <= (cmd.sel_out == OUT_SPREAD) ? -(32'sd32 <<< 24) : -(32'sd16 <<< 24);
        else if (cmd.l_add)
            lacc_reg <= lacc_reg + l_val;
        else if (cmd.l_sub)
            lacc_reg <= lacc_reg - l_val;
        if (cmd.db_mul)
            prod_reg <= lacc_reg * DB_K;
        if (cmd.db_rnd)
            db_reg <= db_next;
    end

    always_comb
    begin
        mag  = prod_reg[59] ? 60'(-prod_reg) : 60'(prod_reg);
        rsum = 61'(mag) + ((cmd.sel_out == OUT_SPREAD) ? (61'd1 << 40) : (61'd1 << 39));
        r    = (cmd.sel_out == OUT_SPREAD) ? {1'b0, rsum[60:41]} : rsum[60:40];
        if (prod_reg[59])
            db_next = (r > 21'd32768) ? 16'h8000 : 16'(-r);
        else
            db_next = (r > 21'd32767) ? 16'h7FFF : r[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_field)
            fld_reg[cmd.sel_out] <= stat.flags[cmd.sel_out] ? DB_FLOOR : db_reg;
        if (cmd.load_out)
        begin
            out_reg.min_db      <= fld_reg[OUT_MIN];
            out_reg.max_db      <= fld_reg[OUT_MAX];
            out_reg.mean_db     <= fld_reg[OUT_MEAN];
            out_reg.spread_db   <= fld_reg[OUT_SPREAD];
            out_reg.item_count  <= count_reg;
            out_reg.floor_flags <= stat.flags;
            out_reg.overflow    <= drop_reg;
        end
    end

    assign out_word = out_reg;

endmodule

>>> rtl/lsdb_ctrl.sv
// Controller: sequences accumulation, log2 iterations, dB scaling and output.
// Depends on lsdb_pkg and level_statistics_db_core_assert.svh.
`include "level_statistics_db_core_assert.svh"

module lsdb_ctrl
    import lsdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    input  logic       out_ready,
    input  lsdb_stat_t stat,
    output logic       in_ready,
    output logic       out_valid,
    output lsdb_cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_ACC   = 12'b000000000001,
        ST_PREP1 = 12'b000000000010,
        ST_PREP2 = 12'b000000000100,
        ST_SEL   = 12'b000000001000,
        ST_LNORM = 12'b000000010000,
        ST_LMUL  = 12'b000000100000,
        ST_LUPD  = 12'b000001000000,
        ST_LADD  = 12'b000010000000,
        ST_DBMUL = 12'b000100000000,
        ST_DBRND = 12'b001000000000,
        ST_WRITE = 12'b010000000000,
        ST_STORE = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] out_idx_reg, out_idx_next;
    logic       second_reg, second_next;
    logic [4:0] iter_reg, iter_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_idx_reg   <= '0;
            second_reg    <= 1'b0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_idx_reg   <= out_idx_next;
            second_reg    <= second_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_idx_next   = out_idx_reg;
        second_next    = second_reg;
        iter_next      = iter_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.sel_out    = out_idx_reg;
        cmd.sel_second = second_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid && in_last)
                    state_next = ST_PREP1;
            end
            ST_PREP1:
            begin
                cmd.prep_mul = 1'b1;
                state_next   = ST_PREP2;
            end
            ST_PREP2:
            begin
                cmd.prep_sum = 1'b1;
                out_idx_next = OUT_MIN;
                state_next   = ST_SEL;
            end
            ST_SEL:
            begin
                second_next = 1'b0;
                if (stat.flags[out_idx_reg])
                    state_next = ST_WRITE;
                else
                begin
                    cmd.l_init     = 1'b1;
                    cmd.log_load   = 1'b1;
                    cmd.sel_second = 1'b0;
                    state_next     = ST_LNORM;
                end
            end
            ST_LNORM:
            begin
                cmd.log_shift = 1'b1;
                if (stat.norm_top)
                begin
                    iter_next  = '0;
                    state_next = ST_LMUL;
                end
            end
            ST_LMUL:
            begin
                cmd.log_mul = 1'b1;
                state_next  = ST_LUPD;
            end
            ST_LUPD:
            begin
                cmd.log_upd = 1'b1;
                if (iter_reg == 5'(LOG_ITERS - 1))
                    state_next = ST_LADD;
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_LMUL;
                end
            end
            ST_LADD:
            begin
                cmd.l_add = !second_reg;
                cmd.l_sub = second_reg;
                if (!second_reg && out_idx_reg[1])
                begin
                    second_next    = 1'b1;
                    cmd.log_load   = 1'b1;
                    cmd.sel_second = 1'b1;
                    state_next     = ST_LNORM;
                end
                else
                    state_next = ST_DBMUL;
            end
            ST_DBMUL:
            begin
                cmd.db_mul = 1'b1;
                state_next = ST_DBRND;
            end
            ST_DBRND:
            begin
                cmd.db_rnd = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_field = 1'b1;
                if (out_idx_reg == OUT_SPREAD)
                    state_next = ST_STORE;
                else
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    state_next   = ST_SEL;
                end
            end
            ST_STORE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    `LSDB_ASSERT_NEXT(a_store_loads, (state_reg == ST_STORE) && cmd.load_out,
        (state_reg == ST_ACC) && out_valid_reg, "result load did not raise out_valid")
    `LSDB_ASSERT_NEXT(a_last_stops, (state_reg == ST_ACC) && in_valid && in_last,
        (state_reg == ST_PREP1) && !in_ready, "last word did not start finalize")
    `LSDB_ASSERT_NEXT(a_iter_end, (state_reg == ST_LUPD) && (iter_reg == 5'(LOG_ITERS - 1)),
        state_reg == ST_LADD, "log iteration count overran")
    `LSDB_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg,
        "pending result dropped")

endmodule

>>> rtl/level_statistics_db_core.sv
// Top level of the level statistics block: min, max, mean and spread in dB.
// Depends on lsdb_pkg, lsdb_ctrl and lsdb_dpath.
//
// Usage:
//   Input channel in_valid/in_ready/in_word carries one RMS level (Q1.16)
//   and a last_item mark. Levels are taken one per cycle while the block
//   accumulates; levels beyond 4096 in a set are dropped and flagged.
//   The word with last_item starts the final pass: one shared log2 unit
//   runs up to six logarithms (normalize one bit per cycle, then 24 squaring
//   steps on a 32x32 multiplier), followed by one multiply and rounding per
//   field, which a floored field skips; the length of the pass depends on
//   that and on the normalize shifts. in_ready stays low over that pass.
//   Output channel out_valid/out_ready/out_word holds one result word in a
//   register; the next set accumulates while it waits. If the receiver
//   still stalls when the next set finishes, the block holds in its store
//   step until the pending word is taken.
//   Reset (rst_n low) clears the accumulators and drops any pending word.
module level_statistics_db_core
    import lsdb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lsdb_in_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output lsdb_out_t out_word
);

    lsdb_cmd_t  cmd;
    lsdb_stat_t stat;

    lsdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_word.last_item),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    lsdb_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (out_word)
    );

endmodule

>>> test/tb_top.sv
// Testbench for level_statistics_db_core: min, max, mean and spread in dB.
// Drives sets of RMS levels with random idling and checks each result word
// against a scoreboard that predicts the statistics. Depends on lsdb_pkg.
module tb_top;
    import lsdb_pkg::*;

    class level_stats_board;
        int unsigned      n_sets;
        longint unsigned  cnt, mn, mx, sum, sq;
        bit               dropped;
        lsdb_out_t        pending[$];
        int               errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            cnt = 0;
            mn = 65536;
            mx = 0;
            sum = 0;
            sq = 0;
            dropped = 0;
        endfunction

        function longint log2_fix(longint unsigned x);
            int e;
            longint unsigned m;
            longint unsigned f;
            f = 0;
            if (x == 0)
                return 0;
            e = 63;
            while (x[e] == 1'b0)
                e--;
            if (e >= 31)
                m = x >> (e - 31);
            else
                m = x << (31 - e);
            for (int i = 0; i < LOG_ITERS; i++)
            begin
                m = (m * m) >> 31;
                f = f << 1;
                if (m >= (64'd2 << 31))
                begin
                    m = m >> 1;
                    f = f | 1;
                end
            end
            return longint'(e) * (64'sd1 <<< 24) + longint'(f);
        endfunction

        function logic [15:0] scale_db(longint l, int shift);
            longint p;
            longint unsigned mag, r;
            p = l * 64'sd101008905;
            mag = (p < 0) ? longint'(-p) : p;
            r = (mag + (64'd1 << (shift - 1))) >> shift;
            if (p < 0)
                return (r > 32768) ? DB_FLOOR : 16'(-longint'(r));
            return (r > 32767) ? 16'h7fff : 16'(r);
        endfunction

        function logic [15:0] amp_db(longint unsigned v, ref logic [3:0] fl, input int b);
            if (v == 0)
            begin
                fl[b] = 1'b1;
                return DB_FLOOR;
            end
            return scale_db(log2_fix(v) - (64'sd16 <<< 24), 40);
        endfunction

        function void note_level(lsdb_in_t w);
            longint unsigned x, nn;
            lsdb_out_t r;
            logic [3:0] fl;
            x = w.rms_level;
            if (x > 65536)
                x = 65536;
            if (cnt < MAX_ITEMS)
            begin
                cnt++;
                if (x < mn)
                    mn = x;
                if (x > mx)
                    mx = x;
                sum += x;
                sq += x * x;
            end
            else
                dropped = 1;
            if (!w.last_item)
                return;
            fl = '0;
            r.min_db = amp_db(mn, fl, OUT_MIN);
            r.max_db = amp_db(mx, fl, OUT_MAX);
            if (cnt == 0 || sum == 0)
            begin
                fl[OUT_MEAN] = 1'b1;
                r.mean_db = DB_FLOOR;
            end
            else
                r.mean_db = scale_db(log2_fix(sum) - log2_fix(cnt) - (64'sd16 <<< 24), 40);
            nn = cnt * sq - sum * sum;
            if (cnt < 2 || nn == 0)
            begin
                fl[OUT_SPREAD] = 1'b1;
                r.spread_db = DB_FLOOR;
            end
            else
                r.spread_db = scale_db(log2_fix(nn) - log2_fix(cnt * (cnt - 1))
                                       - (64'sd32 <<< 24), 41);
            r.item_count = cnt[CNT_W-1:0];
            r.floor_flags = fl;
            r.overflow = dropped;
            pending.push_back(r);
            n_sets++;
            clear();
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endtask

        task check_result(lsdb_out_t g);
            lsdb_out_t e;
            if (pending.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (g.min_db !== e.min_db) report("min_db", g.min_db, e.min_db);
            if (g.max_db !== e.max_db) report("max_db", g.max_db, e.max_db);
            if (g.mean_db !== e.mean_db) report("mean_db", g.mean_db, e.mean_db);
            if (g.spread_db !== e.spread_db) report("spread_db", g.spread_db, e.spread_db);
            if (g.item_count !== e.item_count)
                report("item_count", g.item_count, e.item_count);
            if (g.floor_flags !== e.floor_flags)
                report("floor_flags", g.floor_flags, e.floor_flags);
            if (g.overflow !== e.overflow) report("overflow", g.overflow, e.overflow);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    lsdb_in_t  in_word;
    logic      out_valid;
    logic      out_ready;
    lsdb_out_t out_word;

    level_stats_board board;
    int  send_idle;
    int  recv_stall;
    int  quiet_cycles;

    level_statistics_db_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(out_word);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("level_statistics_db_core regression: fail");
                $finish;
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_level(int unsigned lvl, bit last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word.rms_level <= lvl[LVL_W-1:0];
        in_word.last_item <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_level('{rms_level: lvl[LVL_W-1:0], last_item: last});
    endtask

    function automatic int unsigned rand_level();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(131071, 65536);
            2: return $urandom_range(15);
            3: return 65536;
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic send_set(int len);
        int unsigned v;
        v = rand_level();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(3) != 0)
                v = rand_level();
            send_level(v, i == len - 1);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_level(0, 1);
        send_level(65536, 1);
        send_level(131071, 1);
        send_level(1, 0);
        send_level(65536, 1);
        send_level(0, 0);
        send_level(0, 1);
        send_level(300, 0);
        send_level(300, 0);
        send_level(300, 1);
        send_level(1, 0);
        send_level(2, 0);
        send_level(65535, 1);
        send_level(17'h15555, 0);
        send_level(17'h0aaaa, 1);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1) ? 50 : (ph == 3) ? 10 : 0;
            recv_stall = (ph == 2) ? 50 : (ph == 3) ? 10 : 0;
            for (int s = 0; s < 28; s++)
                send_set($urandom_range(1, 25));
        end
        in_valid <= 1'b0;
        send_idle = 0;
        recv_stall = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        if (board.errors == 0)
            $display("level_statistics_db_core regression: pass");
        else
            $display("level_statistics_db_core regression: fail");
        $finish;
    end
endmodule
